// ----- rtl/core/gcsh_pkg.sv -----
// Shared types, command codes and the bus byte encoder for the GPIB source handshake core.
`default_nettype none

package gcsh_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [4:0] CMD_ATN = 5'd0;
	localparam logic [4:0] CMD_IFC = 5'd1;
	localparam logic [4:0] CMD_SRQ = 5'd2;
	localparam logic [4:0] CMD_REN = 5'd3;
	localparam logic [4:0] CMD_EOI = 5'd4;
	localparam logic [4:0] CMD_MLA = 5'd5;
	localparam logic [4:0] CMD_MTA = 5'd6;
	localparam logic [4:0] CMD_LAD = 5'd7;
	localparam logic [4:0] CMD_UNL = 5'd8;
	localparam logic [4:0] CMD_TAD = 5'd9;
	localparam logic [4:0] CMD_UNT = 5'd10;
	localparam logic [4:0] CMD_SAD = 5'd11;
	localparam logic [4:0] CMD_LLO = 5'd12;
	localparam logic [4:0] CMD_DCL = 5'd13;
	localparam logic [4:0] CMD_PPU = 5'd14;
	localparam logic [4:0] CMD_SPE = 5'd15;
	localparam logic [4:0] CMD_SPD = 5'd16;
	localparam logic [4:0] CMD_GTL = 5'd17;
	localparam logic [4:0] CMD_SDC = 5'd18;
	localparam logic [4:0] CMD_PPC = 5'd19;
	localparam logic [4:0] CMD_GET = 5'd20;
	localparam logic [4:0] CMD_TCT = 5'd21;
	localparam logic [4:0] CMD_PPE = 5'd22;
	localparam logic [4:0] CMD_PPD = 5'd23;
	localparam logic [4:0] CMD_DAB = 5'd24;

	localparam logic [7:0] BYTE_LISTEN = 8'h20;
	localparam logic [7:0] BYTE_TALK = 8'h40;
	localparam logic [7:0] BYTE_UNL = 8'h3F;
	localparam logic [7:0] BYTE_UNT = 8'h5F;
	localparam logic [7:0] BYTE_SECONDARY = 8'h60;
	localparam logic [7:0] BYTE_LLO = 8'h11;
	localparam logic [7:0] BYTE_DCL = 8'h14;
	localparam logic [7:0] BYTE_PPU = 8'h15;
	localparam logic [7:0] BYTE_SPE = 8'h18;
	localparam logic [7:0] BYTE_SPD = 8'h19;
	localparam logic [7:0] BYTE_GTL = 8'h01;
	localparam logic [7:0] BYTE_SDC = 8'h04;
	localparam logic [7:0] BYTE_PPC = 8'h05;
	localparam logic [7:0] BYTE_GET = 8'h08;
	localparam logic [7:0] BYTE_TCT = 8'h09;
	localparam logic [7:0] BYTE_PPE = 8'h60;
	localparam logic [7:0] BYTE_PPD = 8'h70;

	localparam int LN_ATN = 0;
	localparam int LN_DAV = 5;
	localparam int LN_COUNT = 6;

	typedef struct packed {
		logic       req_type;
		logic [4:0] command;
		logic [7:0] value;
		logic       nrfd_asserted;
		logic       ndac_asserted;
	} in_t;

	typedef struct packed {
		logic       atn_drive;
		logic       ifc_drive;
		logic       srq_drive;
		logic       ren_drive;
		logic       eoi_drive;
		logic       dav_drive;
		logic [7:0] bus_byte;
		logic       busy_res;
		logic       done_res;
		logic       status;
	} out_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_LINE = 2'd1,
		KIND_SEND = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] line_idx;
		logic       line_on;
		logic [7:0] code;
		logic       is_cmd;
		logic       nrfd;
		logic       ndac;
	} dec_t;

	function automatic logic [7:0] encode_byte(input logic [4:0] cmd, input logic [7:0] val);
		logic [7:0] b;
		unique case (cmd)
			CMD_MLA: b = BYTE_LISTEN;
			CMD_MTA: b = BYTE_TALK;
			CMD_LAD: b = BYTE_LISTEN + val;
			CMD_UNL: b = BYTE_UNL;
			CMD_TAD: b = BYTE_TALK + val;
			CMD_UNT: b = BYTE_UNT;
			CMD_SAD: b = BYTE_SECONDARY + val;
			CMD_LLO: b = BYTE_LLO;
			CMD_DCL: b = BYTE_DCL;
			CMD_PPU: b = BYTE_PPU;
			CMD_SPE: b = BYTE_SPE;
			CMD_SPD: b = BYTE_SPD;
			CMD_GTL: b = BYTE_GTL;
			CMD_SDC: b = BYTE_SDC;
			CMD_PPC: b = BYTE_PPC;
			CMD_GET: b = BYTE_GET;
			CMD_TCT: b = BYTE_TCT;
			CMD_PPE: b = BYTE_PPE;
			CMD_PPD: b = BYTE_PPD;
			default: b = val;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gpib_command_source_handshake_core.sv -----
// Top level of the GPIB command encoder and source handshake core.
//
//   Channel  Signals                        Carries
//   input    in_valid, in_ready, in_data    one line sample, optionally with a send request
//   output   out_valid, out_ready, out_data one line-drive and status result per input beat
//
// One input beat is accepted per cycle while the four-entry queue has room; each beat
// gives exactly one result, held in the queue and then registered in the result register.
// The handshake engine retires one queued beat per cycle while the result register is
// free or being taken. Reset releases all lines, clears the held byte and empties the
// queue. A stalled output fills the queue, after which in_ready drops.
`default_nettype none

module gpib_command_source_handshake_core (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  gcsh_pkg::in_t  in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output gcsh_pkg::out_t out_data
);

	logic           push;
	gcsh_pkg::dec_t push_data;
	logic           q_full;
	logic           pop;
	logic           q_not_empty;
	gcsh_pkg::dec_t head;

	gcsh_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	gcsh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	gcsh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

// ----- rtl/core/gcsh_front.sv -----
// Front end: accepts input beats, classifies requests and encodes bus bytes.
`default_nettype none

module gcsh_front (
	input  wire            in_valid,
	output logic           in_ready,
	input  gcsh_pkg::in_t  in_data,
	input  wire            q_full,
	output logic           push,
	output gcsh_pkg::dec_t push_data
);

	always_comb begin
		in_ready = !q_full;
		push = in_valid && !q_full;

		push_data.kind = gcsh_pkg::KIND_TICK;
		push_data.line_idx = in_data.command[2:0];
		push_data.line_on = (in_data.value != 8'd0);
		push_data.code = gcsh_pkg::encode_byte(in_data.command, in_data.value);
		push_data.is_cmd = (in_data.command != gcsh_pkg::CMD_DAB);
		push_data.nrfd = in_data.nrfd_asserted;
		push_data.ndac = in_data.ndac_asserted;

		if (in_data.req_type) begin
			if (in_data.command < gcsh_pkg::CMD_MLA) begin
				push_data.kind = gcsh_pkg::KIND_LINE;
			end else if (in_data.command <= gcsh_pkg::CMD_DAB) begin
				push_data.kind = gcsh_pkg::KIND_SEND;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/gcsh_queue.sv -----
// Short queue of classified beats between the front end and the handshake engine.
`default_nettype none

module gcsh_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  gcsh_pkg::dec_t        push_data,
	output logic                  full,
	input  wire                   pop,
	output logic                  not_empty,
	output gcsh_pkg::dec_t        head
);

	gcsh_pkg::dec_t                   mem_q [gcsh_pkg::QDEPTH];
	logic [gcsh_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [gcsh_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [gcsh_pkg::QCNT_W-1:0]      count_q;

	assign full = (count_q == gcsh_pkg::QCNT_W'(gcsh_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/gcsh_back.sv -----
// Back end: runs the source handshake and line drives, and holds the result register.
`default_nettype none

module gcsh_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            q_not_empty,
	input  gcsh_pkg::dec_t head,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_ready,
	output gcsh_pkg::out_t out_data
);

	typedef enum logic [2:0] {
		PH_IDLE      = 3'b001,
		PH_WAIT_NRFD = 3'b010,
		PH_WAIT_NDAC = 3'b100
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic [7:0]                    held_byte_q, held_byte_d;
	logic                          is_cmd_q, is_cmd_d;
	logic [gcsh_pkg::LN_COUNT-1:0] lines_q, lines_d;
	logic                          done, status;
	logic                          out_valid_q;
	gcsh_pkg::out_t                out_q;

	assign pop = q_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		phase_d = phase_q;
		held_byte_d = held_byte_q;
		is_cmd_d = is_cmd_q;
		lines_d = lines_q;
		done = 1'b0;
		status = 1'b0;

		unique case (phase_q)
			PH_WAIT_NRFD: begin
				if (!head.nrfd) begin
					lines_d[gcsh_pkg::LN_DAV] = 1'b1;
					phase_d = PH_WAIT_NDAC;
				end
			end
			PH_WAIT_NDAC: begin
				if (!head.ndac) begin
					lines_d[gcsh_pkg::LN_DAV] = 1'b0;
					if (is_cmd_q) begin
						lines_d[gcsh_pkg::LN_ATN] = 1'b0;
					end
					phase_d = PH_IDLE;
					done = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				unique case (head.kind)
					gcsh_pkg::KIND_LINE: begin
						lines_d[head.line_idx] = head.line_on;
						done = 1'b1;
					end
					gcsh_pkg::KIND_SEND: begin
						lines_d[gcsh_pkg::LN_DAV] = 1'b0;
						if (!head.nrfd && !head.ndac) begin
							lines_d[gcsh_pkg::LN_ATN] = 1'b0;
							done = 1'b1;
							status = 1'b1;
						end else begin
							lines_d[gcsh_pkg::LN_ATN] = head.is_cmd;
							held_byte_d = head.code;
							is_cmd_d = head.is_cmd;
							phase_d = PH_WAIT_NRFD;
						end
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_byte_q <= '0;
			is_cmd_q <= 1'b0;
			lines_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				held_byte_q <= held_byte_d;
				is_cmd_q <= is_cmd_d;
				lines_q <= lines_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.atn_drive <= lines_d[0];
			out_q.ifc_drive <= lines_d[1];
			out_q.srq_drive <= lines_d[2];
			out_q.ren_drive <= lines_d[3];
			out_q.eoi_drive <= lines_d[4];
			out_q.dav_drive <= lines_d[5];
			out_q.bus_byte <= held_byte_d;
			out_q.busy_res <= (phase_d != PH_IDLE);
			out_q.done_res <= done;
			out_q.status <= status;
		end
	end

endmodule

`default_nettype wire
